>>> rtl/dlr_pkg.sv
// ============================================================================
// DDA line rasterizer package
// Shared constants for the line rasterizer and its axis step unit.
// ============================================================================
package dlr_pkg;

    // Default coordinate width in bits (legal range 3 to 6).
    localparam int COORD_BITS_DEF = 6;

endpackage

>>> rtl/dda_line_rasterizer.sv
// ============================================================================
// DDA line rasterizer
// Turns one line segment into its run of rounded grid points.
// ============================================================================
// Usage:
// The input channel (i_in_valid / o_in_ready) takes one segment item made of
// two endpoints. The output channel (o_out_valid / i_out_ready) returns one
// item per plotted point, from the start point to the end point, with
// o_last_point set on the final point. A segment gives steps + 1 points,
// where steps is the larger of the absolute x and y distances.
// Timing: after a segment is accepted, a setup state computes the step
// count, and the first point is offered in the cycle after that. Each
// further point follows in the cycle after the previous one is taken. The
// two per-axis error-term units are reused for every point, which sets the
// pace of one point per cycle while the receiver is ready.
// The block takes one segment at a time: o_in_ready is high only when idle.
// When the receiver stalls, the current point is held unchanged on the
// output ports until it is taken. Reset returns the block to idle with no
// point pending.
// ============================================================================
module dda_line_rasterizer #(
    parameter int COORD_BITS = dlr_pkg::COORD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [COORD_BITS-1:0] i_start_x,
    input  logic [COORD_BITS-1:0] i_start_y,
    input  logic [COORD_BITS-1:0] i_end_x,
    input  logic [COORD_BITS-1:0] i_end_y,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [COORD_BITS-1:0] o_pixel_x,
    output logic [COORD_BITS-1:0] o_pixel_y,
    output logic                  o_last_point
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_RUN
    } t_state;

    t_state r_state, n_state;

    // Segment registers: start point, signed distances, step count and point index.
    logic [COORD_BITS-1:0]        r_org_x, n_org_x;
    logic [COORD_BITS-1:0]        r_org_y, n_org_y;
    logic signed [COORD_BITS:0]   r_dx, n_dx;
    logic signed [COORD_BITS:0]   r_dy, n_dy;
    logic [COORD_BITS-1:0]        r_steps, n_steps;
    logic [COORD_BITS-1:0]        r_idx, n_idx;

    // Per-axis current coordinate (quotient) and error term (remainder).
    logic [COORD_BITS-1:0]        r_qx, n_qx;
    logic [COORD_BITS-1:0]        r_qy, n_qy;
    logic [COORD_BITS:0]          r_rx, n_rx;
    logic [COORD_BITS:0]          r_ry, n_ry;

    logic [COORD_BITS-1:0]        qx_step, qy_step;
    logic [COORD_BITS:0]          rx_step, ry_step;
    logic [COORD_BITS:0]          abs_dx, abs_dy;
    logic                         is_last;

    dlr_axis_step #(.COORD_BITS(COORD_BITS)) u_step_x (
        .i_q      (r_qx),
        .i_r      (r_rx),
        .i_delta  (r_dx),
        .i_steps  (r_steps),
        .o_q_next (qx_step),
        .o_r_next (rx_step)
    );

    dlr_axis_step #(.COORD_BITS(COORD_BITS)) u_step_y (
        .i_q      (r_qy),
        .i_r      (r_ry),
        .i_delta  (r_dy),
        .i_steps  (r_steps),
        .o_q_next (qy_step),
        .o_r_next (ry_step)
    );

    assign abs_dx  = r_dx[COORD_BITS] ? -r_dx : r_dx;
    assign abs_dy  = r_dy[COORD_BITS] ? -r_dy : r_dy;
    assign is_last = (r_idx == r_steps);

    always_comb begin
        n_state = r_state;
        n_org_x = r_org_x;
        n_org_y = r_org_y;
        n_dx    = r_dx;
        n_dy    = r_dy;
        n_steps = r_steps;
        n_idx   = r_idx;
        n_qx    = r_qx;
        n_qy    = r_qy;
        n_rx    = r_rx;
        n_ry    = r_ry;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_org_x = i_start_x;
                    n_org_y = i_start_y;
                    n_dx    = signed'({1'b0, i_end_x}) - signed'({1'b0, i_start_x});
                    n_dy    = signed'({1'b0, i_end_y}) - signed'({1'b0, i_start_y});
                    n_state = ST_SETUP;
                end
            end
            ST_SETUP: begin
                // The step count is the larger distance; it always fits in
                // COORD_BITS bits. Starting the error term at steps gives
                // round-half-up on every point.
                if (abs_dx > abs_dy) begin
                    n_steps = abs_dx[COORD_BITS-1:0];
                    n_rx    = {1'b0, abs_dx[COORD_BITS-1:0]};
                    n_ry    = {1'b0, abs_dx[COORD_BITS-1:0]};
                end else begin
                    n_steps = abs_dy[COORD_BITS-1:0];
                    n_rx    = {1'b0, abs_dy[COORD_BITS-1:0]};
                    n_ry    = {1'b0, abs_dy[COORD_BITS-1:0]};
                end
                n_qx    = r_org_x;
                n_qy    = r_org_y;
                n_idx   = '0;
                n_state = ST_RUN;
            end
            ST_RUN: begin
                if (i_out_ready) begin
                    if (is_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_qx  = qx_step;
                        n_rx  = rx_step;
                        n_qy  = qy_step;
                        n_ry  = ry_step;
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_org_x <= '0;
            r_org_y <= '0;
            r_dx    <= '0;
            r_dy    <= '0;
            r_steps <= '0;
            r_idx   <= '0;
            r_qx    <= '0;
            r_qy    <= '0;
            r_rx    <= '0;
            r_ry    <= '0;
        end else begin
            r_state <= n_state;
            r_org_x <= n_org_x;
            r_org_y <= n_org_y;
            r_dx    <= n_dx;
            r_dy    <= n_dy;
            r_steps <= n_steps;
            r_idx   <= n_idx;
            r_qx    <= n_qx;
            r_qy    <= n_qy;
            r_rx    <= n_rx;
            r_ry    <= n_ry;
        end
    end

    assign o_in_ready   = (r_state == ST_IDLE);
    assign o_out_valid  = (r_state == ST_RUN);
    assign o_pixel_x    = r_qx;
    assign o_pixel_y    = r_qy;
    assign o_last_point = is_last;

endmodule

>>> rtl/dlr_axis_step.sv
// ============================================================================
// DDA axis step unit
// Advances one axis of the line by one point using an exact error term.
// ============================================================================
module dlr_axis_step #(
    parameter int COORD_BITS = dlr_pkg::COORD_BITS_DEF
) (
    input  logic [COORD_BITS-1:0]        i_q,
    input  logic [COORD_BITS:0]          i_r,
    input  logic signed [COORD_BITS:0]   i_delta,
    input  logic [COORD_BITS-1:0]        i_steps,
    output logic [COORD_BITS-1:0]        o_q_next,
    output logic [COORD_BITS:0]          o_r_next
);

    localparam int AW = COORD_BITS + 3;

    logic signed [AW-1:0] two_steps;
    logic signed [AW-1:0] delta2;
    logic signed [AW-1:0] sum;
    logic signed [AW-1:0] r_fix;

    // The remainder stays in [0, 2*steps). Since |delta| <= steps, one step
    // moves the coordinate by at most one in either direction.
    assign two_steps = signed'({2'b00, i_steps, 1'b0});
    assign delta2    = signed'({i_delta[COORD_BITS], i_delta, 1'b0});
    assign sum       = signed'({2'b00, i_r}) + delta2;

    always_comb begin
        if (sum >= two_steps) begin
            r_fix    = sum - two_steps;
            o_q_next = i_q + 1'b1;
        end else if (sum < 0) begin
            r_fix    = sum + two_steps;
            o_q_next = i_q - 1'b1;
        end else begin
            r_fix    = sum;
            o_q_next = i_q;
        end
    end

    assign o_r_next = r_fix[COORD_BITS:0];

endmodule

>>> sim/tb_dda_line_rasterizer.sv
`timescale 1ns / 100ps
// ============================================================================
// DDA line rasterizer testbench
// Feeds line segments through the rasterizer with random gaps on the input
// side and random stalls on the output side, predicts every plotted point
// with exact integer rounding, and checks each returned point in order.
// ============================================================================
module tb_dda_line_rasterizer;

    localparam int CB          = dlr_pkg::COORD_BITS_DEF;
    localparam int COORD_MAX   = (1 << CB) - 1;
    localparam int RANDOM_SEGS = 188;
    // Longest correct stretch without any handshake is a stall burst plus the
    // setup state or a sender gap.
    localparam int STUCK_LIMIT = 2000;
    // Once fewer than this many segments remain, both sides stop idling.
    localparam int QUIET_TAIL  = 20;

    // One segment to rasterize; hold_off makes the sender wait until every
    // predicted point has been returned before offering it.
    typedef struct {
        logic [CB-1:0] sx;
        logic [CB-1:0] sy;
        logic [CB-1:0] ex;
        logic [CB-1:0] ey;
        bit            hold_off;
    } t_segment;

    // One plotted point as the output channel returns it.
    typedef struct {
        logic [CB-1:0] px;
        logic [CB-1:0] py;
        logic          last;
    } t_pixel;

    // Clock, reset and block inputs, all known from time zero.
    logic          i_clk       = 1'b0;
    logic          i_rst_n     = 1'b0;
    logic          i_in_valid  = 1'b0;
    logic [CB-1:0] i_start_x   = '0;
    logic [CB-1:0] i_start_y   = '0;
    logic [CB-1:0] i_end_x     = '0;
    logic [CB-1:0] i_end_y     = '0;
    logic          i_out_ready = 1'b0;

    logic          o_in_ready;
    logic          o_out_valid;
    logic [CB-1:0] o_pixel_x;
    logic [CB-1:0] o_pixel_y;
    logic          o_last_point;

    t_segment pending_segments[$];
    t_pixel   expected_pixels[$];
    t_segment offered_seg;

    int error_count    = 0;
    int segs_taken     = 0;
    int sender_gap     = 0;
    int sender_gap_pct = 0;
    int stall_left     = 0;
    int stall_pct      = 0;
    int stuck_cycles   = 0;

    dda_line_rasterizer #(
        .COORD_BITS (CB)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_start_x    (i_start_x),
        .i_start_y    (i_start_y),
        .i_end_x      (i_end_x),
        .i_end_y      (i_end_y),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_pixel_x    (o_pixel_x),
        .o_pixel_y    (o_pixel_y),
        .o_last_point (o_last_point)
    );

    // 10 ns clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Both sides stop idling for the last few segments so the run ends with
    // a stretch at full rate.
    function automatic bit quiet_tail();
        return pending_segments.size() < QUIET_TAIL;
    endfunction

    // ------------------------------------------------------------------------
    // Point predictor
    // ------------------------------------------------------------------------

    // Rounded interpolation along one axis, halves going up:
    // floor((2*(origin*steps + idx*delta) + steps) / (2*steps)). The point
    // always lies between the endpoints, so the numerator is never negative.
    function automatic logic [CB-1:0] axis_coord(int origin, int delta, int idx,
                                                 int steps);
        int numer;
        numer = 2 * (origin * steps + idx * delta) + steps;
        return CB'(numer / (2 * steps));
    endfunction

    // Appends every point that a segment produces, start to end, to the
    // expected stream. A zero-length segment yields its start point alone.
    task automatic rasterize_segment(t_segment seg);
        int     dx;
        int     dy;
        int     steps;
        t_pixel pix;
        dx    = int'(seg.ex) - int'(seg.sx);
        dy    = int'(seg.ey) - int'(seg.sy);
        steps = (dx < 0) ? -dx : dx;
        if (((dy < 0) ? -dy : dy) > steps) begin
            steps = (dy < 0) ? -dy : dy;
        end
        if (steps == 0) begin
            pix.px   = seg.sx;
            pix.py   = seg.sy;
            pix.last = 1'b1;
            expected_pixels.push_back(pix);
        end else begin
            for (int i = 0; i <= steps; i++) begin
                pix.px   = axis_coord(int'(seg.sx), dx, i, steps);
                pix.py   = axis_coord(int'(seg.sy), dy, i, steps);
                pix.last = (i == steps);
                expected_pixels.push_back(pix);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    task automatic queue_segment(int sx, int sy, int ex, int ey, bit hold_off);
        t_segment seg;
        seg.sx       = CB'(sx);
        seg.sy       = CB'(sy);
        seg.ex       = CB'(ex);
        seg.ey       = CB'(ey);
        seg.hold_off = hold_off;
        pending_segments.push_back(seg);
    endtask

    // Endpoint near a given coordinate, clamped to the grid.
    function automatic int near_coord(int base, int spread);
        int v;
        v = base + $urandom_range(0, 2 * spread) - spread;
        if (v < 0) begin
            v = 0;
        end
        if (v > COORD_MAX) begin
            v = COORD_MAX;
        end
        return v;
    endfunction

    task automatic report_mismatch(string what);
        error_count++;
        $display("MISMATCH @%0t: %s", $realtime, what);
    endtask

    // ------------------------------------------------------------------------
    // Input driver
    // ------------------------------------------------------------------------
    // An offered segment is held until accepted. On acceptance the predictor
    // runs at once, then the driver either opens a gap or offers the next
    // segment. A segment marked hold_off is not offered while points are
    // still owed, which lets the block drain completely at least once.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            sender_gap = 0;
        end else if (!(i_in_valid && !o_in_ready)) begin
            if (i_in_valid) begin
                rasterize_segment(offered_seg);
                segs_taken++;
                // Every 25 segments, pick a new gap density, none included.
                if (segs_taken % 25 == 0) begin
                    case ($urandom_range(0, 2))
                        0:       sender_gap_pct = 0;
                        1:       sender_gap_pct = 25;
                        default: sender_gap_pct = 60;
                    endcase
                end
                if (!quiet_tail() && $urandom_range(0, 99) < sender_gap_pct) begin
                    sender_gap = $urandom_range(1, 8);
                end
            end
            if (sender_gap != 0) begin
                sender_gap--;
                i_in_valid <= 1'b0;
            end else if (pending_segments.size() != 0 &&
                         !(pending_segments[0].hold_off &&
                           expected_pixels.size() != 0)) begin
                offered_seg = pending_segments.pop_front();
                i_start_x  <= offered_seg.sx;
                i_start_y  <= offered_seg.sy;
                i_end_x    <= offered_seg.ex;
                i_end_y    <= offered_seg.ey;
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Output receiver: random stall bursts, with a density that changes as the
    // run goes on and drops to zero at the end.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            stall_left = 0;
        end else if (stall_left != 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
            stall_pct = (segs_taken / 30) % 2 == 0 ? 15 : ((segs_taken / 30) % 3) * 8;
            if (!quiet_tail() && $urandom_range(0, 99) < stall_pct) begin
                stall_left = $urandom_range(1, 8);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Output monitor: each returned point against the oldest expectation.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_pixel want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_pixels.size() == 0) begin
                report_mismatch($sformatf("unexpected point (%0d,%0d) last=%0b",
                                          o_pixel_x, o_pixel_y, o_last_point));
            end else begin
                want = expected_pixels.pop_front();
                if (o_pixel_x !== want.px || o_pixel_y !== want.py ||
                    o_last_point !== want.last) begin
                    report_mismatch($sformatf(
                        "point (%0d,%0d) last=%0b, expected (%0d,%0d) last=%0b",
                        o_pixel_x, o_pixel_y, o_last_point,
                        want.px, want.py, want.last));
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: too many cycles with no handshake on either channel.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                stuck_cycles = 0;
            end else begin
                stuck_cycles++;
            end
            if (stuck_cycles >= STUCK_LIMIT) begin
                $display("tb_dda_line_rasterizer: done, errors");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin
        int sx;
        int sy;

        // Directed segments: zero length at two grid corners, full-length
        // lines along each axis in both directions, both diagonals, shallow
        // and steep lines in several octants, and lines whose intermediate
        // points fall exactly on a half so that upward rounding shows.
        queue_segment(0, 0, 0, 0, 1'b0);
        queue_segment(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 1'b0);
        queue_segment(0, 0, COORD_MAX, 0, 1'b0);
        queue_segment(COORD_MAX, COORD_MAX, 0, COORD_MAX, 1'b0);
        queue_segment(0, 0, 0, COORD_MAX, 1'b0);
        queue_segment(COORD_MAX, COORD_MAX, COORD_MAX, 0, 1'b0);
        queue_segment(0, 0, COORD_MAX, COORD_MAX, 1'b0);
        queue_segment(COORD_MAX, 0, 0, COORD_MAX, 1'b0);
        queue_segment(COORD_MAX, COORD_MAX, 0, 0, 1'b0);
        queue_segment(0, COORD_MAX, COORD_MAX, 0, 1'b0);
        queue_segment(0, 0, 2, 1, 1'b0);
        queue_segment(0, 1, 2, 0, 1'b0);
        queue_segment(2, 1, 0, 0, 1'b0);
        queue_segment(1, 0, 0, 2, 1'b0);
        queue_segment(10, 20, 30, 25, 1'b0);
        queue_segment(40, 10, 35, 50, 1'b0);
        queue_segment(50, 50, 5, 40, 1'b0);
        queue_segment(5, 60, 12, 3, 1'b0);
        queue_segment(0, 0, COORD_MAX, 1, 1'b0);
        queue_segment(21, 42, 42, 21, 1'b0);
        queue_segment(33, 33, 34, 34, 1'b0);
        // Offered only once the block has drained everything before it.
        queue_segment(17, 9, 17, 9, 1'b1);

        for (int n = 0; n < RANDOM_SEGS; n++) begin
            sx = $urandom_range(0, COORD_MAX);
            sy = $urandom_range(0, COORD_MAX);
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    queue_segment(sx, sy, $urandom_range(0, COORD_MAX),
                                  $urandom_range(0, COORD_MAX), 1'b0);
                end
                4, 5: begin
                    // Short segments, where ties in the rounding are common.
                    queue_segment(sx, sy, near_coord(sx, 3), near_coord(sy, 3), 1'b0);
                end
                6: begin
                    queue_segment(sx, sy, $urandom_range(0, COORD_MAX), sy, 1'b0);
                end
                7: begin
                    queue_segment(sx, sy, sx, $urandom_range(0, COORD_MAX), 1'b0);
                end
                8: begin
                    queue_segment(sx, sy, sx, sy, 1'b0);
                end
                default: begin
                    queue_segment(sx, sy, near_coord(sx, 12), near_coord(sy, 12),
                                  n == RANDOM_SEGS / 2);
                end
            endcase
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do begin
            @(posedge i_clk);
        end while (pending_segments.size() != 0 || i_in_valid ||
                   expected_pixels.size() != 0);

        // Let the clock run on to catch any stray extra points.
        repeat (80) @(posedge i_clk);

        if (error_count == 0) begin
            $display("tb_dda_line_rasterizer: done, clean");
        end else begin
            $display("tb_dda_line_rasterizer: done, errors");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/dlr_pkg.sv
rtl/dlr_axis_step.sv
rtl/dda_line_rasterizer.sv
sim/tb_dda_line_rasterizer.sv
